// File: rtl/core/efd_pkg.sv
package efd_pkg;

    localparam int LEN_W    = 32;
    localparam int IDX_W    = 32;
    localparam int SIZE_W   = 24;
    localparam int HLEN_W   = 3;
    localparam int HWORD_W  = 32;

    // One restoring divider cell per quotient bit.
    localparam int DIV_STEPS = LEN_W;

    localparam int HEADER_BYTES_MAX_DEF = 4;
    localparam logic [SIZE_W-1:0] FRAG_SIZE_RESET = SIZE_W'(10000);

    localparam logic [7:0]       MARK_EXT    = 8'h80;
    localparam logic [LEN_W-1:0] SHORT_LIMIT = LEN_W'(128);
    localparam int               BYTE_W      = 8;

    typedef struct packed {
        logic [LEN_W-1:0] event_length;
        logic [IDX_W-1:0] fragment_index;
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0]   fragment_count;
        logic [SIZE_W-1:0]  prefix_bytes;
        logic [LEN_W-1:0]   fragment_offset;
        logic [SIZE_W-1:0]  fragment_bytes;
        logic [HWORD_W-1:0] header_word;
        logic [HLEN_W-1:0]  header_size;
        logic               empty_event;
    } t_rsp;

    // Partial division state handed from one cell to the next.
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] rem;
        logic [LEN_W-1:0]  dvd;
        logic [IDX_W-1:0]  idx;
    } t_div_slot;

endpackage

// File: rtl/core/efd_div_cell.sv
module efd_div_cell
    import efd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_size,
    input  t_div_slot         i_slot,
    output t_div_slot         o_slot
);

    logic [SIZE_W:0] w_trial;
    logic            w_fits;
    t_div_slot       n_slot;
    t_div_slot       r_slot;

    // Shift in the next dividend bit and try one subtraction.
    always_comb begin
        w_trial = {i_slot.rem, i_slot.dvd[LEN_W-1]};
        w_fits  = w_trial >= {1'b0, i_size};
        n_slot  = i_slot;
        if (w_fits) begin
            n_slot.rem = SIZE_W'(w_trial - {1'b0, i_size});
        end else begin
            n_slot.rem = w_trial[SIZE_W-1:0];
        end
        n_slot.dvd = {i_slot.dvd[LEN_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.rem <= n_slot.rem;
        r_slot.dvd <= n_slot.dvd;
        r_slot.idx <= n_slot.idx;
    end

    assign o_slot = r_slot;

endmodule

// File: rtl/core/efd_finish.sv
module efd_finish
    import efd_pkg::*;
#(
    parameter int HEADER_BYTES_MAX = HEADER_BYTES_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_size,
    input  t_div_slot         i_slot,
    output logic              o_done,
    output t_rsp              o_rsp
);

    localparam int FALLBACK_NB = HEADER_BYTES_MAX - 1;

    // First stage: count, prefix and the (index - 1) * size product.
    logic              r_v1, n_v1;
    logic              r_empty, n_empty;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  r_extra, n_extra;
    logic [SIZE_W-1:0] r_prefix, n_prefix;
    logic              r_idx_zero, n_idx_zero;
    logic [LEN_W-1:0]  r_prod, n_prod;
    logic              w_rem_nz;

    always_comb begin
        w_rem_nz   = i_slot.rem != '0;
        n_v1       = i_slot.valid;
        n_empty    = !w_rem_nz && (i_slot.dvd == '0);
        n_count    = i_slot.dvd + LEN_W'(w_rem_nz);
        n_extra    = w_rem_nz ? i_slot.dvd : i_slot.dvd - LEN_W'(1);
        n_prefix   = w_rem_nz ? i_slot.rem : i_size;
        n_idx_zero = i_slot.idx == '0;
        n_prod     = LEN_W'((i_slot.idx - IDX_W'(1)) * i_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        r_empty    <= n_empty;
        r_count    <= n_count;
        r_extra    <= n_extra;
        r_prefix   <= n_prefix;
        r_idx_zero <= n_idx_zero;
        r_prod     <= n_prod;
    end

    // Second stage: offset and the additional-fragment header.
    logic [HWORD_W-1:0] w_hword;
    logic [HLEN_W-1:0]  w_hlen;
    logic               r_done;
    t_rsp               r_rsp, n_rsp;

    always_comb begin
        w_hword = HWORD_W'(MARK_EXT | 8'(FALLBACK_NB))
                | HWORD_W'((r_extra & ((LEN_W'(1) << (BYTE_W * FALLBACK_NB)) - LEN_W'(1)))
                           << BYTE_W);
        w_hlen  = HLEN_W'(HEADER_BYTES_MAX);
        // Walk downward so the smallest fitting byte count wins.
        for (int i = HEADER_BYTES_MAX - 2; i >= 1; i--) begin
            if ((r_extra >> (BYTE_W * i)) == '0) begin
                w_hword = HWORD_W'(MARK_EXT | 8'(i)) | HWORD_W'(r_extra << BYTE_W);
                w_hlen  = HLEN_W'(i + 1);
            end
        end
        if (r_extra < SHORT_LIMIT) begin
            w_hword = HWORD_W'(r_extra);
            w_hlen  = HLEN_W'(1);
        end

        n_rsp.fragment_count  = r_count;
        n_rsp.prefix_bytes    = r_prefix;
        n_rsp.fragment_offset = r_idx_zero ? '0 : LEN_W'(r_prefix) + r_prod;
        n_rsp.fragment_bytes  = r_idx_zero ? r_prefix : i_size;
        n_rsp.header_word     = w_hword;
        n_rsp.header_size     = w_hlen;
        n_rsp.empty_event     = 1'b0;
        if (r_empty) begin
            n_rsp             = '0;
            n_rsp.empty_event = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v1;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// File: rtl/core/event_fragment_descriptor.sv
// Event fragment descriptor.
//
// Command channel: a transaction is taken at a rising edge where i_start is
// high and o_busy is low. o_busy is always low, so a new command may be
// issued in every cycle. i_cmd carries the event length and fragment index.
// Result channel: o_done is high for exactly one cycle with the matching
// o_rsp; the receiver cannot stall it and must take it in that cycle.
// From accept to o_done a transaction passes the row of 32 restoring
// divider cells (one quotient bit per cell), a register stage for the
// count, prefix and the offset multiplier, and a last one for the offset add
// and header encoding. Throughput is one transaction per cycle, set by the
// divider row, where every cell advances its slot each cycle.
// Configuration: i_cfg_we writes the fragment size from i_cfg_wdata; a size
// of zero is stored as one. It must only change while no transaction is in
// flight. Reset clears the pipeline valid bits and loads a size of 10000.
module event_fragment_descriptor
    import efd_pkg::*;
#(
    parameter int HEADER_BYTES_MAX = HEADER_BYTES_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output t_rsp              o_rsp
);

    localparam int LATENCY = DIV_STEPS + 2;

    // Effective fragment size. Storing the zero-to-one substitution here keeps
    // it out of every divider cell.
    logic [SIZE_W-1:0] r_size, n_size;

    always_comb begin
        n_size = r_size;
        if (i_cfg_we) begin
            n_size = (i_cfg_wdata == '0) ? SIZE_W'(1) : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= FRAG_SIZE_RESET;
        end else begin
            r_size <= n_size;
        end
    end

    // The pipeline never holds back a command.
    assign o_busy = 1'b0;

    // Divider row: slot 0 is the incoming command, slot k+1 the output of cell k.
    t_div_slot w_slot [0:DIV_STEPS];

    always_comb begin
        w_slot[0].valid = i_start && !o_busy;
        w_slot[0].rem   = '0;
        w_slot[0].dvd   = i_cmd.event_length;
        w_slot[0].idx   = i_cmd.fragment_index;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        efd_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_size (r_size),
            .i_slot (w_slot[k]),
            .o_slot (w_slot[k+1])
        );
    end

    // After the last cell the slot holds quotient and remainder.
    efd_finish #(
        .HEADER_BYTES_MAX(HEADER_BYTES_MAX)
    ) u_finish (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_size (r_size),
        .i_slot (w_slot[DIV_STEPS]),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // Every accepted transaction must produce a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("result strobe missing after accepted transaction");

    // An empty event reports no fragments and no header.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.empty_event) |->
            (o_rsp.fragment_count == '0 && o_rsp.header_size == '0))
        else $error("empty event carries nonzero results");

    // A non-empty event has at least one fragment, nonzero lengths and a header.
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.empty_event) |->
            (o_rsp.fragment_count != '0 && o_rsp.prefix_bytes != '0
             && o_rsp.header_size != '0))
        else $error("non-empty event with zero count, prefix or header");

endmodule
